### hw/rtl/acms_pkg.sv
// Shared types, codes and constants of the clutch and motor sequencer.
package acms_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 29;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_KEY = 2'd1;
	localparam logic [1:0] ACT_FRAME = 2'd2;

	localparam logic [7:0] KEY_UP_LC = 8'h77;      // 'w'
	localparam logic [7:0] KEY_UP_UC = 8'h57;      // 'W'
	localparam logic [7:0] KEY_DOWN_LC = 8'h73;    // 's'
	localparam logic [7:0] KEY_DOWN_UC = 8'h53;    // 'S'
	localparam logic [7:0] KEY_ENGAGE_LC = 8'h65;  // 'e'
	localparam logic [7:0] KEY_ENGAGE_UC = 8'h45;  // 'E'
	localparam logic [7:0] KEY_SPACE = 8'h20;      // ' '
	localparam logic [7:0] KEY_RELEASE_LC = 8'h78; // 'x'
	localparam logic [7:0] KEY_RELEASE_UC = 8'h58; // 'X'

	localparam logic [7:0] REPORT_TYPE_POSITION = 8'd152;
	localparam logic [3:0] REPORT_LENGTH = 4'd8;
	localparam logic [12:0] HOME_POSITION = 13'd600;

	localparam logic [28:0] RST_REPORT_FRAME_ID = 29'h00FF0001;
	localparam logic [15:0] RST_LEAD_TIME_MS = 16'd25;
	localparam logic [15:0] RST_KEY_TIMEOUT_MS = 16'd800;
	localparam logic [11:0] RST_STEP_COUNTS = 12'd100;
	localparam logic [12:0] RST_POSITION_MIN = 13'd550;
	localparam logic [12:0] RST_POSITION_MAX = 13'd3450;
	localparam logic [15:0] RST_FRESH_WINDOW_MS = 16'd500;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_REPORT_FRAME_ID = 3'd0,
		CFG_LEAD_TIME_MS    = 3'd1,
		CFG_KEY_TIMEOUT_MS  = 3'd2,
		CFG_STEP_COUNTS     = 3'd3,
		CFG_POSITION_MIN    = 3'd4,
		CFG_POSITION_MAX    = 3'd5,
		CFG_FRESH_WINDOW_MS = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [28:0] report_frame_id;
		logic [15:0] lead_time_ms;
		logic [15:0] key_timeout_ms;
		logic [11:0] step_counts;
		logic [12:0] position_min;
		logic [12:0] position_max;
		logic [15:0] fresh_window_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  key_code;
		logic        frame_extended;
		logic [28:0] frame_id;
		logic [3:0]  frame_length;
		logic [7:0]  report_type;
		logic [15:0] shaft_counts;
		logic [7:0]  error_flags;
		logic [15:0] current_ma;
	} item_t;

	typedef struct packed {
		logic [7:0]  cmd_position_low;
		logic [7:0]  cmd_flags_position_high;
		logic [12:0] target_position;
		logic        engage_wanted;
		logic        clutch_on;
		logic        motor_on;
		logic        link_alive;
		logic        report_live;
		logic [15:0] last_shaft;
		logic [15:0] last_current;
		logic [7:0]  last_errors;
	} result_t;

endpackage

### hw/rtl/acms_cfg_regs.sv
// Configuration register file of the clutch and motor sequencer.
module acms_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [acms_pkg::CFG_INDEX_BITS-1:0] wr_index,
	input  logic [acms_pkg::CFG_DATA_BITS-1:0]  wr_data,
	output acms_pkg::cfg_t                     cfg
);

	acms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.report_frame_id <= acms_pkg::RST_REPORT_FRAME_ID;
			cfg_q.lead_time_ms <= acms_pkg::RST_LEAD_TIME_MS;
			cfg_q.key_timeout_ms <= acms_pkg::RST_KEY_TIMEOUT_MS;
			cfg_q.step_counts <= acms_pkg::RST_STEP_COUNTS;
			cfg_q.position_min <= acms_pkg::RST_POSITION_MIN;
			cfg_q.position_max <= acms_pkg::RST_POSITION_MAX;
			cfg_q.fresh_window_ms <= acms_pkg::RST_FRESH_WINDOW_MS;
		end else if (wr_en) begin
			case (acms_pkg::cfg_index_t'(wr_index))
				acms_pkg::CFG_REPORT_FRAME_ID: cfg_q.report_frame_id <= wr_data;
				acms_pkg::CFG_LEAD_TIME_MS:    cfg_q.lead_time_ms <= wr_data[15:0];
				acms_pkg::CFG_KEY_TIMEOUT_MS:  cfg_q.key_timeout_ms <= wr_data[15:0];
				acms_pkg::CFG_STEP_COUNTS:     cfg_q.step_counts <= wr_data[11:0];
				acms_pkg::CFG_POSITION_MIN:    cfg_q.position_min <= wr_data[12:0];
				acms_pkg::CFG_POSITION_MAX:    cfg_q.position_max <= wr_data[12:0];
				acms_pkg::CFG_FRESH_WINDOW_MS: cfg_q.fresh_window_ms <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/acms_core.sv
// Sequencer state and the single-pass update that one item makes to it.
module acms_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  acms_pkg::item_t   item,
	input  acms_pkg::cfg_t    cfg,
	output acms_pkg::result_t result
);

	localparam int TB = acms_pkg::TIME_BITS;

	logic [TB-1:0] now_q, stage_time_q, last_key_q, last_frame_q, last_report_q;
	logic          have_report_q;
	logic [15:0]   shaft_q, current_q;
	logic [7:0]    errors_q;
	logic [12:0]   target_q;
	logic          want_q, clutch_q, motor_q;

	logic [TB-1:0] now_n, stage_time_n, last_key_n, last_frame_n, last_report_n;
	logic          have_report_n;
	logic [15:0]   shaft_n, current_n;
	logic [7:0]    errors_n;
	logic [12:0]   target_n, counts;
	logic          want_a, want_n, clutch_n, motor_n;
	logic          frame_hit, report_hit, lead_done;
	logic [TB-1:0] key_age, stage_age, frame_age, report_age;

	// Clamp, testing the minimum first: a value below the minimum gets it, even when it lies above the maximum.
	function automatic logic [12:0] clamp_pos(input logic signed [17:0] v,
		input logic [12:0] lo, input logic [12:0] hi);
		logic signed [17:0] lo_s, hi_s;
		lo_s = $signed({5'b0, lo});
		hi_s = $signed({5'b0, hi});
		if (v < lo_s) return lo;
		else if (v > hi_s) return hi;
		else return v[12:0];
	endfunction

	always_comb begin
		now_n = now_q + TB'(item.action == acms_pkg::ACT_TICK);
		last_key_n = last_key_q;
		target_n = target_q;
		want_a = want_q;
		if (item.action == acms_pkg::ACT_KEY) begin
			last_key_n = now_q;
			case (item.key_code)
				acms_pkg::KEY_UP_LC, acms_pkg::KEY_UP_UC: begin
					want_a = 1'b1;
					target_n = clamp_pos($signed({5'b0, target_q}) + $signed({6'b0, cfg.step_counts}),
						cfg.position_min, cfg.position_max);
				end
				acms_pkg::KEY_DOWN_LC, acms_pkg::KEY_DOWN_UC: begin
					want_a = 1'b1;
					target_n = clamp_pos($signed({5'b0, target_q}) - $signed({6'b0, cfg.step_counts}),
						cfg.position_min, cfg.position_max);
				end
				acms_pkg::KEY_ENGAGE_LC, acms_pkg::KEY_ENGAGE_UC, acms_pkg::KEY_SPACE: begin
					want_a = 1'b1;
					if (have_report_q)
						target_n = clamp_pos($signed({2'b0, shaft_q}),
							cfg.position_min, cfg.position_max);
				end
				acms_pkg::KEY_RELEASE_LC, acms_pkg::KEY_RELEASE_UC: want_a = 1'b0;
				default: begin
				end
			endcase
		end

		frame_hit = (item.action == acms_pkg::ACT_FRAME) && item.frame_extended &&
			(item.frame_id == cfg.report_frame_id);
		report_hit = frame_hit && (item.frame_length == acms_pkg::REPORT_LENGTH) &&
			(item.report_type == acms_pkg::REPORT_TYPE_POSITION);
		last_frame_n = frame_hit ? now_q : last_frame_q;
		last_report_n = report_hit ? now_q : last_report_q;
		have_report_n = have_report_q | report_hit;
		shaft_n = report_hit ? item.shaft_counts : shaft_q;
		current_n = report_hit ? item.current_ma : current_q;
		errors_n = report_hit ? item.error_flags : errors_q;

		// Deadman: a stale operator drops the engage request.
		key_age = now_n - last_key_n;
		want_n = want_a && !(key_age > TB'(cfg.key_timeout_ms));

		// At most one clutch or motor transition per item.
		stage_age = now_n - stage_time_q;
		lead_done = stage_age >= TB'(cfg.lead_time_ms);
		stage_time_n = stage_time_q;
		clutch_n = clutch_q;
		motor_n = motor_q;
		if (want_n) begin
			if (!clutch_q) begin
				clutch_n = 1'b1;
				stage_time_n = now_n;
			end else if (!motor_q && lead_done) begin
				motor_n = 1'b1;
			end
		end else begin
			if (motor_q) begin
				motor_n = 1'b0;
				stage_time_n = now_n;
			end else if (clutch_q && lead_done) begin
				clutch_n = 1'b0;
			end
		end

		frame_age = now_n - last_frame_n;
		report_age = now_n - last_report_n;
		counts = clamp_pos($signed({5'b0, target_n}), cfg.position_min, cfg.position_max);

		result.cmd_position_low = counts[7:0];
		result.cmd_flags_position_high = {clutch_n, motor_n, 1'b0, counts[12:8]};
		result.target_position = counts;
		result.engage_wanted = want_n;
		result.clutch_on = clutch_n;
		result.motor_on = motor_n;
		result.link_alive = frame_age < TB'(cfg.fresh_window_ms);
		result.report_live = have_report_n && (report_age < TB'(cfg.fresh_window_ms));
		result.last_shaft = shaft_n;
		result.last_current = current_n;
		result.last_errors = errors_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			stage_time_q <= '0;
			last_key_q <= '0;
			last_frame_q <= '0;
			last_report_q <= '0;
			have_report_q <= 1'b0;
			shaft_q <= '0;
			current_q <= '0;
			errors_q <= '0;
			target_q <= acms_pkg::HOME_POSITION;
			want_q <= 1'b0;
			clutch_q <= 1'b0;
			motor_q <= 1'b0;
		end else if (go) begin
			now_q <= now_n;
			stage_time_q <= stage_time_n;
			last_key_q <= last_key_n;
			last_frame_q <= last_frame_n;
			last_report_q <= last_report_n;
			have_report_q <= have_report_n;
			shaft_q <= shaft_n;
			current_q <= current_n;
			errors_q <= errors_n;
			target_q <= target_n;
			want_q <= want_n;
			clutch_q <= clutch_n;
			motor_q <= motor_n;
		end
	end

	// The motor never runs with the clutch open.
	a_motor_needs_clutch: assert property (@(posedge clk) disable iff (!arst_n)
		motor_q |-> clutch_q) else $error("motor on with clutch off");

	// The motor starts only after the clutch was already closed.
	a_motor_after_clutch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(motor_q) |-> $past(clutch_q) && want_q)
		else $error("motor started without a closed clutch");

	// The clutch opens only without an engage request and with the motor off.
	a_clutch_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clutch_q) |-> !want_q && !$past(motor_q))
		else $error("clutch opened while engaged or motor running");

	// Time advances by at most one millisecond per update.
	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(now_q) |-> now_q == $past(now_q) + TB'(1))
		else $error("millisecond counter jumped");

endmodule

### hw/rtl/actuator_clutch_motor_sequencer_unit.sv
// Top level of the clutch and motor sequencer: ports, input stage and result register.
//
// The unit keeps a target position for a linear actuator and stages its clutch and motor
// enables: on engage the clutch closes first and the motor follows once lead_time_ms
// ticks have passed; on release the motor stops first and the clutch opens after the same
// lead time. Each item is a one millisecond tick (action 0), an operator key byte
// (action 1) or a received frame (action 2); action 3 changes nothing but still runs the
// deadman and staging checks. The keys w/W and s/S step the target by step_counts and
// request engage, e/E and space request engage and, once a report is held, copy the
// clamped shaft position, x/X drops the request, and every key refreshes the deadman
// timer, which drops the request once more than key_timeout_ms ticks pass with no key. Only
// extended frames with the report_frame_id identifier count: they refresh link_alive,
// and an eight-byte frame of type 152 also stores shaft, error and current data. Every
// item yields exactly one result item. An item is taken into the input register when it
// is accepted, and its result is registered in the result register when the item leaves
// the input register. The unit sustains one item per clock while the result side does
// not stall, since the sequencer state registers are read and updated in one pass. The
// input stalls only while both the input register and the result register are full and
// the result side stalls. The configuration port is always ready and is meant to be
// written while no item is in flight. Directly after reset link_alive reads 1 until
// fresh_window_ms ticks have passed, since the frame time stamp starts at zero.
module actuator_clutch_motor_sequencer_unit (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [acms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [acms_pkg::CFG_DATA_BITS-1:0]  cfg_data,

	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          action,
	input  logic [7:0]                          key_code,
	input  logic                                frame_extended,
	input  logic [28:0]                         frame_id,
	input  logic [3:0]                          frame_length,
	input  logic [7:0]                          report_type,
	input  logic [15:0]                         shaft_counts,
	input  logic [7:0]                          error_flags,
	input  logic [15:0]                         current_ma,

	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [7:0]                          cmd_position_low,
	output logic [7:0]                          cmd_flags_position_high,
	output logic [12:0]                         target_position,
	output logic                                engage_wanted,
	output logic                                clutch_on,
	output logic                                motor_on,
	output logic                                link_alive,
	output logic                                report_live,
	output logic [15:0]                         last_shaft,
	output logic [15:0]                         last_current,
	output logic [7:0]                          last_errors
);

	acms_pkg::cfg_t    cfg;
	acms_pkg::item_t   item_s1;
	logic              item_valid_s1;
	acms_pkg::result_t result_s2;
	logic              result_valid_s2;
	acms_pkg::result_t core_result;
	logic              advance;

	// The configuration registers take a write in every cycle.
	assign cfg_ready = 1'b1;

	acms_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The item in the input register is processed when the result register can take it.
	assign advance = item_valid_s1 && (!result_valid_s2 || !result_stall);
	assign item_stall = item_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1.action <= action;
			item_s1.key_code <= key_code;
			item_s1.frame_extended <= frame_extended;
			item_s1.frame_id <= frame_id;
			item_s1.frame_length <= frame_length;
			item_s1.report_type <= report_type;
			item_s1.shaft_counts <= shaft_counts;
			item_s1.error_flags <= error_flags;
			item_s1.current_ma <= current_ma;
		end
	end

	acms_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign result_valid = result_valid_s2;
	assign cmd_position_low = result_s2.cmd_position_low;
	assign cmd_flags_position_high = result_s2.cmd_flags_position_high;
	assign target_position = result_s2.target_position;
	assign engage_wanted = result_s2.engage_wanted;
	assign clutch_on = result_s2.clutch_on;
	assign motor_on = result_s2.motor_on;
	assign link_alive = result_s2.link_alive;
	assign report_live = result_s2.report_live;
	assign last_shaft = result_s2.last_shaft;
	assign last_current = result_s2.last_current;
	assign last_errors = result_s2.last_errors;

endmodule

### sim/actuator_clutch_motor_sequencer_unit_tb.sv
// Self-checking testbench for the actuator clutch and motor sequencer unit.
`timescale 1ns / 100ps

module actuator_clutch_motor_sequencer_unit_tb;

	// Action code three carries no action of its own; the package has no name for it.
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned REPORT_LIMIT = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [acms_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [acms_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	logic item_valid = 1'b0;
	logic item_stall;
	acms_pkg::item_t item_out = '0;

	logic [1:0] action;
	logic [7:0] key_code;
	logic frame_extended;
	logic [28:0] frame_id;
	logic [3:0] frame_length;
	logic [7:0] report_type;
	logic [15:0] shaft_counts;
	logic [7:0] error_flags;
	logic [15:0] current_ma;

	logic result_valid;
	logic result_stall = 1'b0;
	logic [7:0] cmd_position_low;
	logic [7:0] cmd_flags_position_high;
	logic [12:0] target_position;
	logic engage_wanted;
	logic clutch_on;
	logic motor_on;
	logic link_alive;
	logic report_live;
	logic [15:0] last_shaft;
	logic [15:0] last_current;
	logic [7:0] last_errors;

	// Items still to be offered to the unit, and commands predicted but not yet seen.
	acms_pkg::item_t items_waiting[$];
	acms_pkg::result_t commands_due[$];

	// When set, neither side inserts gaps or stalls, giving a stretch at full rate.
	bit steady_feed = 1'b0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	// Shadow of the sequencer: its registers and every piece of its state.
	acms_pkg::cfg_t seq_cfg;
	logic [31:0] ms_now = '0;
	logic [31:0] stage_stamp = '0;
	logic [31:0] key_stamp = '0;
	logic [31:0] frame_stamp = '0;
	logic [31:0] report_stamp = '0;
	logic report_held = 1'b0;
	logic [15:0] shaft_hold = '0;
	logic [15:0] current_hold = '0;
	logic [7:0] errors_hold = '0;
	logic [12:0] target_hold = acms_pkg::HOME_POSITION;
	logic engage_req = 1'b0;
	logic clutch_st = 1'b0;
	logic motor_st = 1'b0;

	always #6 clk = ~clk;

	assign action = item_out.action;
	assign key_code = item_out.key_code;
	assign frame_extended = item_out.frame_extended;
	assign frame_id = item_out.frame_id;
	assign frame_length = item_out.frame_length;
	assign report_type = item_out.report_type;
	assign shaft_counts = item_out.shaft_counts;
	assign error_flags = item_out.error_flags;
	assign current_ma = item_out.current_ma;

	actuator_clutch_motor_sequencer_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.key_code(key_code),
		.frame_extended(frame_extended),
		.frame_id(frame_id),
		.frame_length(frame_length),
		.report_type(report_type),
		.shaft_counts(shaft_counts),
		.error_flags(error_flags),
		.current_ma(current_ma),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cmd_position_low(cmd_position_low),
		.cmd_flags_position_high(cmd_flags_position_high),
		.target_position(target_position),
		.engage_wanted(engage_wanted),
		.clutch_on(clutch_on),
		.motor_on(motor_on),
		.link_alive(link_alive),
		.report_live(report_live),
		.last_shaft(last_shaft),
		.last_current(last_current),
		.last_errors(last_errors)
	);

	// Milliseconds since a time stamp; the subtraction wraps like the 32-bit clock.
	function automatic logic [31:0] ms_since(input logic [31:0] stamp);
		return ms_now - stamp;
	endfunction

	// The lower limit wins only when the value is below it, even if it exceeds the upper one.
	function automatic logic [12:0] clamp_target(input int v);
		if (v < int'(seq_cfg.position_min))
			return seq_cfg.position_min;
		if (v > int'(seq_cfg.position_max))
			return seq_cfg.position_max;
		return v[12:0];
	endfunction

	// Advances the shadow state by one item and returns the command the unit must show.
	function automatic acms_pkg::result_t next_command(input acms_pkg::item_t it);
		acms_pkg::result_t r;
		logic [12:0] counts;
		case (it.action)
			acms_pkg::ACT_TICK: ms_now = ms_now + 32'd1;
			acms_pkg::ACT_KEY: begin
				// Any byte at all counts as operator activity for the deadman timer.
				key_stamp = ms_now;
				case (it.key_code)
					acms_pkg::KEY_UP_LC, acms_pkg::KEY_UP_UC: begin
						engage_req = 1'b1;
						target_hold = clamp_target(int'(target_hold) + int'(seq_cfg.step_counts));
					end
					acms_pkg::KEY_DOWN_LC, acms_pkg::KEY_DOWN_UC: begin
						engage_req = 1'b1;
						target_hold = clamp_target(int'(target_hold) - int'(seq_cfg.step_counts));
					end
					acms_pkg::KEY_ENGAGE_LC, acms_pkg::KEY_ENGAGE_UC, acms_pkg::KEY_SPACE: begin
						engage_req = 1'b1;
						if (report_held)
							target_hold = clamp_target(int'(shaft_hold));
					end
					acms_pkg::KEY_RELEASE_LC, acms_pkg::KEY_RELEASE_UC: engage_req = 1'b0;
					default: ;
				endcase
			end
			acms_pkg::ACT_FRAME: begin
				if (it.frame_extended && it.frame_id == seq_cfg.report_frame_id) begin
					frame_stamp = ms_now;
					if (it.frame_length == acms_pkg::REPORT_LENGTH &&
							it.report_type == acms_pkg::REPORT_TYPE_POSITION) begin
						shaft_hold = it.shaft_counts;
						errors_hold = it.error_flags;
						current_hold = it.current_ma;
						report_stamp = ms_now;
						report_held = 1'b1;
					end
				end
			end
			default: ;
		endcase

		if (engage_req && ms_since(key_stamp) > 32'(seq_cfg.key_timeout_ms))
			engage_req = 1'b0;

		// At most one transition per item: clutch before motor on engage, the reverse on release.
		if (engage_req) begin
			if (!clutch_st) begin
				clutch_st = 1'b1;
				stage_stamp = ms_now;
			end else if (!motor_st && ms_since(stage_stamp) >= 32'(seq_cfg.lead_time_ms)) begin
				motor_st = 1'b1;
			end
		end else begin
			if (motor_st) begin
				motor_st = 1'b0;
				stage_stamp = ms_now;
			end else if (clutch_st && ms_since(stage_stamp) >= 32'(seq_cfg.lead_time_ms)) begin
				clutch_st = 1'b0;
			end
		end

		// The stored target is shown through the limits in force now, not those at store time.
		counts = clamp_target(int'(target_hold));
		r.cmd_position_low = counts[7:0];
		r.cmd_flags_position_high = {clutch_st, motor_st, 1'b0, counts[12:8]};
		r.target_position = counts;
		r.engage_wanted = engage_req;
		r.clutch_on = clutch_st;
		r.motor_on = motor_st;
		r.link_alive = ms_since(frame_stamp) < 32'(seq_cfg.fresh_window_ms);
		r.report_live = report_held &&
			(ms_since(report_stamp) < 32'(seq_cfg.fresh_window_ms));
		r.last_shaft = shaft_hold;
		r.last_current = current_hold;
		r.last_errors = errors_hold;
		return r;
	endfunction

	// Every field random, so that fields the unit ignores still toggle.
	function automatic acms_pkg::item_t random_fields();
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		return bits[$bits(acms_pkg::item_t)-1:0];
	endfunction

	function automatic acms_pkg::item_t tick_item();
		acms_pkg::item_t it;
		it = random_fields();
		it.action = acms_pkg::ACT_TICK;
		return it;
	endfunction

	function automatic acms_pkg::item_t key_item(input logic [7:0] k);
		acms_pkg::item_t it;
		it = random_fields();
		it.action = acms_pkg::ACT_KEY;
		it.key_code = k;
		return it;
	endfunction

	function automatic acms_pkg::item_t frame_item(input logic ext, input logic [28:0] id,
			input logic [3:0] len, input logic [7:0] kind, input logic [15:0] shaft,
			input logic [7:0] errs, input logic [15:0] amps);
		acms_pkg::item_t it;
		it = random_fields();
		it.action = acms_pkg::ACT_FRAME;
		it.frame_extended = ext;
		it.frame_id = id;
		it.frame_length = len;
		it.report_type = kind;
		it.shaft_counts = shaft;
		it.error_flags = errs;
		it.current_ma = amps;
		return it;
	endfunction

	// Mostly ticks, operator keys and well-formed reports for the configured identifier;
	// the rest are damaged frames, the idle action code and plain noise.
	function automatic acms_pkg::item_t random_item();
		acms_pkg::item_t it;
		int pick;
		logic [31:0] rnd;
		it = random_fields();
		pick = $urandom_range(99);
		rnd = $urandom;
		if (pick < 55) begin
			it.action = acms_pkg::ACT_TICK;
		end else if (pick < 75) begin
			it.action = acms_pkg::ACT_KEY;
			case ($urandom_range(10))
				0: it.key_code = acms_pkg::KEY_UP_LC;
				1: it.key_code = acms_pkg::KEY_UP_UC;
				2: it.key_code = acms_pkg::KEY_DOWN_LC;
				3: it.key_code = acms_pkg::KEY_DOWN_UC;
				4: it.key_code = acms_pkg::KEY_ENGAGE_LC;
				5: it.key_code = acms_pkg::KEY_ENGAGE_UC;
				6: it.key_code = acms_pkg::KEY_SPACE;
				7: it.key_code = acms_pkg::KEY_RELEASE_LC;
				8: it.key_code = acms_pkg::KEY_RELEASE_UC;
				default: ;
			endcase
		end else if (pick < 92) begin
			it.action = acms_pkg::ACT_FRAME;
			it.frame_extended = 1'b1;
			it.frame_id = seq_cfg.report_frame_id;
			it.frame_length = acms_pkg::REPORT_LENGTH;
			it.report_type = acms_pkg::REPORT_TYPE_POSITION;
			// For half of the reports the shaft reading is cut to the 13 bits of a position.
			if (rnd[0])
				it.shaft_counts[15:13] = 3'b000;
			if (rnd[7:4] < 4'd4) begin
				case (rnd[9:8])
					2'd0: it.frame_length = rnd[15:12];
					2'd1: it.report_type = rnd[23:16];
					2'd2: it.frame_extended = 1'b0;
					default: it.frame_id = it.frame_id ^ (29'd1 << rnd[28:24]);
				endcase
			end
		end else if (pick < 96) begin
			it.action = ACT_NONE;
		end
		return it;
	endfunction

	task automatic field_check(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
		end
	endtask

	// Driver: offers the next waiting item, holding it unchanged while the unit stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				commands_due.push_back(next_command(item_out));
			if (!item_valid || !item_stall) begin
				if (items_waiting.size() > 0 && (steady_feed || $urandom_range(99) >= 29)) begin
					item_out <= items_waiting.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted command item against the oldest prediction.
	always @(posedge clk) begin
		acms_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (commands_due.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("command item with no prediction waiting");
				end else begin
					want = commands_due.pop_front();
					field_check("cmd_position_low", 32'(want.cmd_position_low),
						32'(cmd_position_low));
					field_check("cmd_flags_position_high", 32'(want.cmd_flags_position_high),
						32'(cmd_flags_position_high));
					field_check("target_position", 32'(want.target_position),
						32'(target_position));
					field_check("engage_wanted", 32'(want.engage_wanted), 32'(engage_wanted));
					field_check("clutch_on", 32'(want.clutch_on), 32'(clutch_on));
					field_check("motor_on", 32'(want.motor_on), 32'(motor_on));
					field_check("link_alive", 32'(want.link_alive), 32'(link_alive));
					field_check("report_live", 32'(want.report_live), 32'(report_live));
					field_check("last_shaft", 32'(want.last_shaft), 32'(last_shaft));
					field_check("last_current", 32'(want.last_current), 32'(last_current));
					field_check("last_errors", 32'(want.last_errors), 32'(last_errors));
				end
			end
			result_stall <= !steady_feed && ($urandom_range(99) < 29);
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// One register write; the shadow copy follows at the edge where the write is taken.
	task automatic write_register(input acms_pkg::cfg_index_t idx, input logic [28:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			acms_pkg::CFG_REPORT_FRAME_ID: seq_cfg.report_frame_id = value;
			acms_pkg::CFG_LEAD_TIME_MS: seq_cfg.lead_time_ms = value[15:0];
			acms_pkg::CFG_KEY_TIMEOUT_MS: seq_cfg.key_timeout_ms = value[15:0];
			acms_pkg::CFG_STEP_COUNTS: seq_cfg.step_counts = value[11:0];
			acms_pkg::CFG_POSITION_MIN: seq_cfg.position_min = value[12:0];
			acms_pkg::CFG_POSITION_MAX: seq_cfg.position_max = value[12:0];
			acms_pkg::CFG_FRESH_WINDOW_MS: seq_cfg.fresh_window_ms = value[15:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [28:0] id, input logic [15:0] lead,
			input logic [15:0] timeout, input logic [11:0] step, input logic [12:0] lo,
			input logic [12:0] hi, input logic [15:0] fresh);
		write_register(acms_pkg::CFG_REPORT_FRAME_ID, id);
		write_register(acms_pkg::CFG_LEAD_TIME_MS, 29'(lead));
		write_register(acms_pkg::CFG_KEY_TIMEOUT_MS, 29'(timeout));
		write_register(acms_pkg::CFG_STEP_COUNTS, 29'(step));
		write_register(acms_pkg::CFG_POSITION_MIN, 29'(lo));
		write_register(acms_pkg::CFG_POSITION_MAX, 29'(hi));
		write_register(acms_pkg::CFG_FRESH_WINDOW_MS, 29'(fresh));
	endtask

	// Waits until every item has gone in and every command has come out, then lets the
	// two-stage pipeline settle before registers are touched again. The check runs on
	// the falling edge so that the driver's updates of the rising edge are already seen.
	task automatic wait_idle();
		do @(negedge clk);
		while (items_waiting.size() != 0 || item_valid || commands_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		repeat (count) items_waiting.push_back(random_item());
		wait_idle();
	endtask

	initial begin
		logic [31:0] rnd;
		seq_cfg = '{acms_pkg::RST_REPORT_FRAME_ID, acms_pkg::RST_LEAD_TIME_MS,
			acms_pkg::RST_KEY_TIMEOUT_MS, acms_pkg::RST_STEP_COUNTS,
			acms_pkg::RST_POSITION_MIN, acms_pkg::RST_POSITION_MAX,
			acms_pkg::RST_FRESH_WINDOW_MS};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Short lead, deadman and freshness times let each effect show up
		// within a handful of ticks; the step is the largest so both clamps are hit.
		apply_settings(acms_pkg::RST_REPORT_FRAME_ID, 16'd2, 16'd3, 12'd4095,
			acms_pkg::RST_POSITION_MIN, acms_pkg::RST_POSITION_MAX, 16'd3);
		// After reset the link looks alive until the freshness window has run out.
		repeat (3) items_waiting.push_back(tick_item());
		items_waiting.push_back(random_fields());
		items_waiting[$].action = ACT_NONE;
		// Engage with a step up to the upper clamp; clutch first, motor after the lead time.
		items_waiting.push_back(key_item(acms_pkg::KEY_UP_LC));
		repeat (2) items_waiting.push_back(tick_item());
		// Step below zero lands on the lower clamp, then release: motor off, later clutch off.
		items_waiting.push_back(key_item(acms_pkg::KEY_DOWN_UC));
		items_waiting.push_back(key_item(acms_pkg::KEY_RELEASE_LC));
		repeat (2) items_waiting.push_back(tick_item());
		// A full report with extreme contents, then frames that each miss one condition.
		items_waiting.push_back(frame_item(1'b1, acms_pkg::RST_REPORT_FRAME_ID,
			acms_pkg::REPORT_LENGTH, acms_pkg::REPORT_TYPE_POSITION, 16'hFFFF, 8'hFF,
			16'hFFFF));
		items_waiting.push_back(frame_item(1'b1, acms_pkg::RST_REPORT_FRAME_ID, 4'd7,
			acms_pkg::REPORT_TYPE_POSITION, 16'h0000, 8'h00, 16'h0000));
		items_waiting.push_back(frame_item(1'b1, acms_pkg::RST_REPORT_FRAME_ID,
			acms_pkg::REPORT_LENGTH, 8'd151, 16'h0000, 8'h00, 16'h0000));
		items_waiting.push_back(frame_item(1'b0, acms_pkg::RST_REPORT_FRAME_ID,
			acms_pkg::REPORT_LENGTH, acms_pkg::REPORT_TYPE_POSITION, 16'h0000, 8'h00,
			16'h0000));
		items_waiting.push_back(frame_item(1'b1, acms_pkg::RST_REPORT_FRAME_ID ^ 29'd1,
			acms_pkg::REPORT_LENGTH, acms_pkg::REPORT_TYPE_POSITION, 16'h0000, 8'h00,
			16'h0000));
		// Every remaining key, including one the unit does not know.
		items_waiting.push_back(key_item(acms_pkg::KEY_SPACE));
		items_waiting.push_back(key_item(acms_pkg::KEY_ENGAGE_UC));
		items_waiting.push_back(key_item(acms_pkg::KEY_UP_UC));
		items_waiting.push_back(key_item(acms_pkg::KEY_DOWN_LC));
		items_waiting.push_back(key_item(acms_pkg::KEY_ENGAGE_LC));
		items_waiting.push_back(key_item(acms_pkg::KEY_RELEASE_UC));
		items_waiting.push_back(key_item(8'hFF));
		// Engage and let the deadman timer run out without another key.
		items_waiting.push_back(key_item(acms_pkg::KEY_UP_LC));
		repeat (4) items_waiting.push_back(tick_item());
		wait_idle();

		// Reset values again, with the stored target left where the directed part put it.
		apply_settings(acms_pkg::RST_REPORT_FRAME_ID, acms_pkg::RST_LEAD_TIME_MS,
			acms_pkg::RST_KEY_TIMEOUT_MS, acms_pkg::RST_STEP_COUNTS,
			acms_pkg::RST_POSITION_MIN, acms_pkg::RST_POSITION_MAX,
			acms_pkg::RST_FRESH_WINDOW_MS);
		run_random(200);

		// Short times so staging, deadman and freshness all turn over many times.
		rnd = $urandom;
		apply_settings(rnd[28:0], 16'd3, 16'd20, 12'd4095, 13'd0, 13'h1FFF, 16'd10);
		run_random(250);

		// Zero on every time and step, all-ones identifier, lower limit above the upper one.
		apply_settings(29'h1FFFFFFF, 16'd0, 16'd0, 12'd0, 13'h1FFF, 13'd0, 16'd0);
		run_random(150);

		// Longest times, narrow position range, zero identifier; this phase also runs without gaps.
		steady_feed = 1'b1;
		apply_settings(29'd0, 16'hFFFF, 16'hFFFF, 12'd1, 13'd1000, 13'd1200, 16'hFFFF);
		run_random(150);
		steady_feed = 1'b0;

		// Random settings with times small enough to matter within the phase.
		repeat (2) begin
			rnd = $urandom;
			apply_settings(rnd[28:0], 16'($urandom_range(40)), 16'($urandom_range(200)),
				12'($urandom_range(4095)), 13'($urandom_range(8191)), 13'($urandom_range(8191)),
				16'($urandom_range(100)));
			run_random(120);
		end

		if (fail_count == 0 && commands_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
